/* rtl/core/stq_pkg.sv */
`default_nettype none
package stq_pkg;

	localparam int KIND_W     = 2;
	localparam int INTERVAL_W = 31;
	localparam int ID_W       = 32;
	localparam int TIME_W     = 48;
	localparam int ORDER_W    = 32;
	localparam int EVENT_W    = 3;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [EVENT_W-1:0] event_t;

	localparam kind_t KIND_START = 2'd0;
	localparam kind_t KIND_STOP  = 2'd1;
	localparam kind_t KIND_TICK  = 2'd2;

	localparam event_t EV_STARTED  = 3'd0;
	localparam event_t EV_STOPPED  = 3'd1;
	localparam event_t EV_NOTFOUND = 3'd2;
	localparam event_t EV_EXPIRED  = 3'd3;
	localparam event_t EV_FULL     = 3'd4;

endpackage
`default_nettype wire

/* rtl/core/software_timer_queue.sv */
`default_nettype none
// Timer table with TIMERS slots. A request carries a kind: start (arm a
// one-shot or periodic timer, answered with a fresh id or a table-full result),
// stop (remove the timer with the given id, the earliest in queue order if ids
// repeat) or tick (advance the millisecond time and report every due timer,
// earliest expiry first, ties in insertion order; periodic timers are rearmed).
// A start or stop request walks the slot table once through a single registered
// read port and one shared key comparator; a tick that reports k timers walks
// it k+1 times, or TIMERS times when all TIMERS slots expire. A request of the
// fourth, unused kind is accepted and dropped without a walk or a result. A
// result that waits for the output register to free holds the walk back.
// The block accepts no request while a walk is running; a finished result
// waits in the output register while the next request is taken.
module software_timer_queue #(
	parameter int TIMERS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [stq_pkg::IN_DATA_W-1:0]    s_tdata,  // interval[30:0], periodic[31], timer_id[63:32]
	input  wire logic [stq_pkg::KIND_W-1:0]       s_tuser,  // kind[1:0]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [stq_pkg::OUT_DATA_W-1:0]        m_tdata,  // result_id[31:0]
	output logic [stq_pkg::EVENT_W-1:0]           m_tuser,  // event_res[2:0]
	output logic                                  m_tlast
);
	import stq_pkg::*;

	localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CNT_W = $clog2(TIMERS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMERS - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIMERS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ACT   = 2'd3;

	logic [1:0]            state_q;
	kind_t                 kind_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic                  periodic_q;
	logic [ID_W-1:0]       tid_q;
	logic [TIME_W-1:0]     now_q;
	logic [ID_W-1:0]       next_id_q;
	logic [ORDER_W-1:0]    ins_q;
	logic [TIMERS-1:0]     valid_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      n_q;

	logic [ID_W-1:0]       mem_id     [TIMERS];
	logic [TIME_W-1:0]     mem_expire [TIMERS];
	logic [INTERVAL_W-1:0] mem_period [TIMERS];
	logic [ORDER_W-1:0]    mem_order  [TIMERS];

	logic                  eval_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic [ID_W-1:0]       id_s1;
	logic [TIME_W-1:0]     expire_s1;
	logic [INTERVAL_W-1:0] period_s1;
	logic [ORDER_W-1:0]    order_s1;

	logic                  found_q;
	logic [IDX_W-1:0]      best_slot_q;
	logic [TIME_W-1:0]     best_expire_q;
	logic [ORDER_W-1:0]    best_order_q;
	logic [ID_W-1:0]       best_id_q;
	logic [INTERVAL_W-1:0] best_period_q;
	logic                  pend_q;
	logic [ID_W-1:0]       pend_id_q;

	logic                  m_tvalid_q;
	logic [ID_W-1:0]       m_id_q;
	event_t                m_ev_q;
	logic                  m_last_q;

	logic                  out_free;
	logic                  key_lt;
	logic                  take;
	logic [INTERVAL_W-1:0] interval_eff;
	logic [INTERVAL_W-1:0] add_b;
	logic [TIME_W-1:0]     arm_expire;
	logic                  emit_en;
	event_t                emit_ev;
	logic [ID_W-1:0]       emit_id;
	logic                  emit_last;
	logic                  wr_new;
	logic                  wr_arm;
	logic                  clr_en;
	logic                  act_done;
	logic                  act_rescan;
	logic                  act_flush;
	logic                  in_fire;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_id_q;
	assign m_tuser  = m_ev_q;
	assign m_tlast  = m_last_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign interval_eff = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;
	assign add_b        = (kind_q == KIND_START) ? interval_eff : best_period_q;
	assign arm_expire   = now_q + {{(TIME_W - INTERVAL_W){1'b0}}, add_b};
	assign key_lt       = {expire_s1, order_s1} < {best_expire_q, best_order_q};

	// candidate test for the slot whose data just came out of the table
	always_comb begin
		take = 1'b0;
		if (eval_s1) begin
			unique case (kind_q)
				KIND_START: take = !vld_s1 && !found_q;
				KIND_STOP:  take = vld_s1 && (id_s1 == tid_q) && (!found_q || key_lt);
				KIND_TICK:  take = vld_s1 && (expire_s1 <= now_q) && (!found_q || key_lt);
				default:    take = 1'b0;
			endcase
		end
	end

	always_comb begin
		emit_en    = 1'b0;
		emit_ev    = EV_STARTED;
		emit_id    = '0;
		emit_last  = 1'b1;
		wr_new     = 1'b0;
		wr_arm     = 1'b0;
		clr_en     = 1'b0;
		act_done   = 1'b0;
		act_rescan = 1'b0;
		act_flush  = 1'b0;
		if (state_q == ST_ACT) begin
			unique case (kind_q)
				KIND_START: begin
					if (out_free) begin
						emit_en  = 1'b1;
						act_done = 1'b1;
						if (found_q) begin
							emit_ev = EV_STARTED;
							emit_id = next_id_q + ID_W'(1);
							wr_new  = 1'b1;
						end else begin
							emit_ev = EV_FULL;
						end
					end
				end
				KIND_STOP: begin
					if (out_free) begin
						emit_en  = 1'b1;
						act_done = 1'b1;
						emit_id  = tid_q;
						emit_ev  = found_q ? EV_STOPPED : EV_NOTFOUND;
						clr_en   = found_q;
					end
				end
				KIND_TICK: begin
					emit_ev = EV_EXPIRED;
					emit_id = pend_id_q;
					if (!found_q) begin
						if (!pend_q) begin
							act_done = 1'b1;
						end else if (out_free) begin
							emit_en  = 1'b1;
							act_done = 1'b1;
						end
					end else if (!pend_q || out_free) begin
						emit_en   = pend_q;
						emit_last = 1'b0;
						wr_arm    = (best_period_q != '0);
						clr_en    = (best_period_q == '0);
						if (n_q == CNT_LAST) begin
							act_flush = 1'b1;
						end else begin
							act_rescan = 1'b1;
						end
					end
				end
				default: act_done = 1'b1;
			endcase
		end
	end

	// slot table: one read port swept by the scan index, one write port
	always_ff @(posedge clk) begin
		id_s1     <= mem_id[idx_q];
		expire_s1 <= mem_expire[idx_q];
		period_s1 <= mem_period[idx_q];
		order_s1  <= mem_order[idx_q];
		if (wr_new) begin
			mem_id[best_slot_q]     <= next_id_q + ID_W'(1);
			mem_period[best_slot_q] <= periodic_q ? interval_eff : '0;
		end
		if (wr_new || wr_arm) begin
			mem_expire[best_slot_q] <= arm_expire;
			mem_order[best_slot_q]  <= ins_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (in_fire) begin
			kind_q     <= s_tuser;
			interval_q <= s_tdata[INTERVAL_W-1:0];
			periodic_q <= s_tdata[INTERVAL_W];
			tid_q      <= s_tdata[IN_DATA_W-1:IN_DATA_W-ID_W];
		end
		if (take) begin
			best_slot_q   <= idx_s1;
			best_expire_q <= expire_s1;
			best_order_q  <= order_s1;
			best_id_q     <= id_s1;
			best_period_q <= period_s1;
		end
		if (act_rescan || act_flush) begin
			pend_id_q <= best_id_q;
		end
		if (emit_en) begin
			m_id_q   <= emit_id;
			m_ev_q   <= emit_ev;
			m_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			next_id_q  <= '0;
			ins_q      <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			eval_s1    <= 1'b0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			eval_s1 <= (state_q == ST_SCAN);
			vld_s1  <= valid_q[idx_q];
			if (take) begin
				found_q <= 1'b1;
			end
			if (emit_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (wr_new) begin
				valid_q[best_slot_q] <= 1'b1;
				next_id_q            <= next_id_q + ID_W'(1);
			end
			if (clr_en) begin
				valid_q[best_slot_q] <= 1'b0;
			end
			if (wr_new || wr_arm) begin
				ins_q <= ins_q + ORDER_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_tuser == KIND_START || s_tuser == KIND_STOP ||
					                s_tuser == KIND_TICK)) begin
						idx_q   <= '0;
						n_q     <= '0;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN;
						if (s_tuser == KIND_TICK) begin
							now_q <= now_q + TIME_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (act_done) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (act_rescan || act_flush) begin
						pend_q  <= 1'b1;
						n_q     <= n_q + CNT_W'(1);
						found_q <= 1'b0;
						if (act_rescan) begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* bench/tb_software_timer_queue.sv */
module tb_software_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import stq_pkg::*;

	localparam int TIMERS       = 16;
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = (TIMERS + 3) * (TIMERS + 2) + 60;
	localparam int HOLD_CYCLES  = 400;
	localparam kind_t KIND_SPARE = 2'd3;

	typedef struct {
		kind_t             kind;
		logic [30:0]       interval;
		logic              periodic;
		logic [ID_W-1:0]   timer_id;
	} timer_request_t;

	typedef struct packed {
		event_t            ev;
		logic [ID_W-1:0]   id;
		logic              fin;
	} timer_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [EVENT_W-1:0] m_tuser;
	logic m_tlast;

	timer_request_t timer_requests[$];
	timer_report_t timer_reports[$];
	timer_request_t offered_request;
	timer_report_t oldest_report;
	int mismatches = 0;

	// timer table as the block should hold it
	logic              armed [TIMERS];
	logic [ID_W-1:0]   armed_id [TIMERS];
	logic [TIME_W-1:0] due_at [TIMERS];
	logic [30:0]       period_of [TIMERS];
	logic [ORDER_W-1:0] seq_of [TIMERS];
	logic [TIME_W-1:0] now_ms = '0;
	logic [ID_W-1:0]   last_id = '0;
	logic [ORDER_W-1:0] seq_next = '0;

	software_timer_queue #(.TIMERS(TIMERS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit comes_first(int a, int b);
		if (due_at[a] != due_at[b])
			return due_at[a] < due_at[b];
		return seq_of[a] < seq_of[b];
	endfunction

	function automatic void rearm(int s, logic [30:0] delay);
		due_at[s] = now_ms + TIME_W'(delay);
		seq_of[s] = seq_next;
		seq_next = seq_next + 1'b1;
	endfunction

	function automatic void apply_timer_request(timer_request_t r);
		int slot;
		int n;
		logic [30:0] ivl;
		slot = -1;
		case (r.kind)
			KIND_START: begin
				for (int i = 0; i < TIMERS; i++)
					if (!armed[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					timer_reports.push_back('{EV_FULL, '0, 1'b1});
				end else begin
					ivl = (r.interval == 0) ? 31'd1 : r.interval;
					last_id = last_id + 1'b1;
					armed[slot] = 1'b1;
					armed_id[slot] = last_id;
					period_of[slot] = r.periodic ? ivl : '0;
					rearm(slot, ivl);
					timer_reports.push_back('{EV_STARTED, last_id, 1'b1});
				end
			end
			KIND_STOP: begin
				for (int i = 0; i < TIMERS; i++)
					if (armed[i] && armed_id[i] == r.timer_id && (slot < 0 || comes_first(i, slot)))
						slot = i;
				if (slot < 0) begin
					timer_reports.push_back('{EV_NOTFOUND, r.timer_id, 1'b1});
				end else begin
					armed[slot] = 1'b0;
					timer_reports.push_back('{EV_STOPPED, r.timer_id, 1'b1});
				end
			end
			KIND_TICK: begin
				now_ms = now_ms + 1'b1;
				for (n = 0; n < TIMERS; n++) begin
					slot = -1;
					for (int i = 0; i < TIMERS; i++)
						if (armed[i] && due_at[i] <= now_ms && (slot < 0 || comes_first(i, slot)))
							slot = i;
					if (slot < 0)
						break;
					timer_reports.push_back('{EV_EXPIRED, armed_id[slot], 1'b0});
					if (period_of[slot] != 0)
						rearm(slot, period_of[slot]);
					else
						armed[slot] = 1'b0;
				end
				if (n > 0)
					timer_reports[timer_reports.size() - 1].fin = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		if (r < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [30:0] pick_interval();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 31'($urandom_range(0, 4));
		if (r < 15)
			return 31'($urandom_range(5, 30));
		if (r < 17)
			return 31'($urandom_range(31, 300));
		return 31'($urandom);
	endfunction

	function automatic logic [ID_W-1:0] pick_stop_id();
		logic [ID_W-1:0] ids[$];
		int r;
		for (int i = 0; i < TIMERS; i++)
			if (armed[i])
				ids.push_back(armed_id[i]);
		r = $urandom_range(0, 19);
		if (r < 14 && ids.size() > 0)
			return ids[$urandom_range(0, ids.size() - 1)];
		if (r < 17)
			return $urandom_range(0, last_id + 2);
		return $urandom;
	endfunction

	task automatic queue_request(kind_t kind, logic [30:0] interval, logic periodic,
			logic [ID_W-1:0] timer_id);
		while (timer_requests.size() >= 4)
			@(negedge clk);
		timer_requests.push_back('{kind, interval, periodic, timer_id});
	endtask

	task automatic wait_drained();
		while (!(timer_requests.size() == 0 && !s_tvalid && timer_reports.size() == 0))
			@(negedge clk);
	endtask

	// sender
	int send_gap;
	int tx_level;
	int tx_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
			tx_level <= 0;
			tx_cycles <= 0;
		end else begin
			tx_cycles <= tx_cycles + 1;
			if (tx_cycles % 256 == 0)
				tx_level <= $urandom_range(0, 3);
			if (s_tvalid && s_tready)
				apply_timer_request(offered_request);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (timer_requests.size() > 0) begin
					offered_request = timer_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered_request.timer_id, offered_request.periodic,
						offered_request.interval};
					s_tuser <= offered_request.kind;
					send_gap <= (tx_level != 0 && $urandom_range(0, 7) < tx_level) ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	int ready_gap;
	int hold_left;
	int reports_taken;
	int next_hold_at;
	int rx_level;
	int rx_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_gap <= 0;
			hold_left <= 0;
			reports_taken <= 0;
			next_hold_at <= 80;
			rx_level <= 0;
			rx_cycles <= 0;
		end else begin
			rx_cycles <= rx_cycles + 1;
			if (rx_cycles % 256 == 128)
				rx_level <= $urandom_range(0, 3);
			if (m_tvalid && m_tready)
				reports_taken <= reports_taken + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (reports_taken >= next_hold_at) begin
				hold_left <= HOLD_CYCLES;
				next_hold_at <= next_hold_at + 220;
				m_tready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap <= ready_gap - 1;
				m_tready <= 1'b0;
			end else if (rx_level != 0 && $urandom_range(0, 7) < rx_level) begin
				ready_gap <= pick_gap() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (timer_reports.size() == 0) begin
				$error("unexpected result: event_res %0d result_id %0d last %0b",
					m_tuser, m_tdata, m_tlast);
				mismatches++;
			end else begin
				oldest_report = timer_reports.pop_front();
				if (m_tuser !== oldest_report.ev) begin
					$error("event_res: expected %0d, got %0d", oldest_report.ev, m_tuser);
					mismatches++;
				end
				if (m_tdata !== oldest_report.id) begin
					$error("result_id: expected %0d, got %0d", oldest_report.id, m_tdata);
					mismatches++;
				end
				if (m_tlast !== oldest_report.fin) begin
					$error("last: expected %0b, got %0b", oldest_report.fin, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int issued;
		int r;
		for (int i = 0; i < TIMERS; i++) begin
			armed[i] = 1'b0;
			armed_id[i] = '0;
			due_at[i] = '0;
			period_of[i] = '0;
			seq_of[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_request(KIND_TICK, 31'($urandom), 1'b1, $urandom);
		queue_request(KIND_SPARE, 31'($urandom), 1'b0, $urandom);
		queue_request(KIND_STOP, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		queue_request(KIND_START, 31'd0, 1'b0, 32'hFFFF_FFFF);
		queue_request(KIND_START, 31'd0, 1'b1, '0);
		queue_request(KIND_START, 31'd1, 1'b0, $urandom);
		queue_request(KIND_START, 31'h7FFF_FFFF, 1'b1, $urandom);
		for (int i = 0; i < TIMERS - 4; i++)
			queue_request(KIND_START, 31'd2, i[0], $urandom);
		queue_request(KIND_START, 31'd5, 1'b1, $urandom);
		queue_request(KIND_TICK, 31'($urandom), 1'b0, $urandom);
		queue_request(KIND_STOP, 31'($urandom), 1'b0, 32'd4);
		queue_request(KIND_STOP, 31'($urandom), 1'b1, 32'd4);
		queue_request(KIND_TICK, '0, 1'b0, '0);
		queue_request(KIND_TICK, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			if (issued == RANDOM_ITEMS / 2)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < 35) begin
				queue_request(KIND_START, pick_interval(), $urandom_range(0, 9) < 4, $urandom);
				issued++;
			end else if (r < 60) begin
				queue_request(KIND_STOP, 31'($urandom), 1'($urandom), pick_stop_id());
				issued++;
			end else if (r < 95) begin
				queue_request(KIND_TICK, 31'($urandom), 1'($urandom), $urandom);
				issued++;
			end else begin
				queue_request(KIND_SPARE, 31'($urandom), 1'($urandom), $urandom);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && timer_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
